>>> hw/rtl/sound_mailbox_irq_controller_assert.svh
`ifndef SOUND_MAILBOX_IRQ_CONTROLLER_ASSERT_SVH
`define SOUND_MAILBOX_IRQ_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMIC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMIC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smic_pkg.sv
`default_nettype none

package smic_pkg;

  typedef enum logic [2:0] {
    MODE_MAIN_RD  = 3'd0,
    MODE_MAIN_WRB = 3'd1,
    MODE_MAIN_WRW = 3'd2,
    MODE_SUB_RD   = 3'd3,
    MODE_SUB_WR   = 3'd4,
    MODE_FM_LEVEL = 3'd5,
    MODE_INT_ACK  = 3'd6,
    MODE_INIT     = 3'd7
  } smic_mode_t;

  // main side offsets
  localparam logic [4:0] MAIN_LATCH_LO = 5'h00;
  localparam logic [4:0] MAIN_LATCH_HI = 5'h01;
  localparam logic [4:0] MAIN_UP_LO    = 5'h02;
  localparam logic [4:0] MAIN_UP_HI    = 5'h03;
  localparam logic [4:0] MAIN_CMD_IRQ  = 5'h04;
  localparam logic [4:0] MAIN_STATUS   = 5'h05;
  localparam logic [4:0] MAIN_ACK_ALT  = 5'h06;

  // sub side offsets
  localparam logic [4:0] SUB_HANDSHAKE = 5'h00;
  localparam logic [4:0] SUB_CMD_EOI   = 5'h01;
  localparam logic [4:0] SUB_FM_EOI    = 5'h02;
  localparam logic [4:0] SUB_CMD_EOI2  = 5'h03;
  localparam logic [4:0] SUB_DOWN_LO   = 5'h10;
  localparam logic [4:0] SUB_DOWN_HI   = 5'h11;
  localparam logic [4:0] SUB_STATUS    = 5'h12;
  localparam logic [4:0] SUB_UP_LO     = 5'h18;
  localparam logic [4:0] SUB_UP_HI     = 5'h19;

  localparam logic [7:0] VEC_CMD  = 8'hdf;
  localparam logic [7:0] VEC_FM   = 8'hd7;
  localparam logic [7:0] VEC_NONE = 8'h00;
  localparam logic [7:0] UNMAPPED = 8'hff;

  typedef struct packed {
    smic_mode_t  mode;
    logic [4:0]  offset;
    logic [15:0] data;
    logic [1:0]  byte_enables;
  } smic_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_line;
    logic       spurious;
  } smic_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/smic_core.sv
`default_nettype none
`include "sound_mailbox_irq_controller_assert.svh"

module smic_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire smic_pkg::smic_item_t item,
  output smic_pkg::smic_result_t    result
);
  import smic_pkg::*;

  logic [7:0] down_latch [2];
  logic [7:0] up_latch [2];
  logic       down_pending, up_pending;
  logic       fm_request, cmd_request, fm_in_service, cmd_in_service;

  logic [7:0] down_latch_next [2];
  logic [7:0] up_latch_next [2];
  logic       down_pending_next, up_pending_next;
  logic       fm_request_next, cmd_request_next;
  logic       fm_in_service_next, cmd_in_service_next;
  logic [7:0] rd;
  logic       spur;
  logic       cmd_ready, fm_ready, line_now;

  assign cmd_ready = cmd_request && !cmd_in_service;
  assign fm_ready  = fm_request && !fm_in_service;
  assign line_now  = cmd_ready || fm_ready;

  always_comb begin
    down_latch_next     = down_latch;
    up_latch_next       = up_latch;
    down_pending_next   = down_pending;
    up_pending_next     = up_pending;
    fm_request_next     = fm_request;
    cmd_request_next    = cmd_request;
    fm_in_service_next  = fm_in_service;
    cmd_in_service_next = cmd_in_service;
    rd   = VEC_NONE;
    spur = 1'b0;
    case (item.mode)
      MODE_MAIN_RD: begin
        if (item.offset == MAIN_UP_LO || item.offset == MAIN_UP_HI) begin
          rd = up_latch[item.offset[0]];
        end else if (item.offset == MAIN_STATUS) begin
          rd = {7'd0, down_pending};
        end else begin
          rd = UNMAPPED;
        end
      end
      MODE_MAIN_WRB: begin
        if (item.offset == MAIN_LATCH_LO || item.offset == MAIN_LATCH_HI) begin
          down_latch_next[item.offset[0]] = item.data[7:0];
        end else if (item.offset == MAIN_CMD_IRQ) begin
          cmd_request_next = 1'b1;
        end else if (item.offset == MAIN_UP_LO || item.offset == MAIN_ACK_ALT) begin
          up_pending_next   = 1'b0;
          down_pending_next = 1'b1;
        end
      end
      MODE_MAIN_WRW: begin
        if (item.byte_enables[0]) begin
          down_latch_next[0] = item.data[7:0];
        end
        if (item.byte_enables[1]) begin
          down_latch_next[1] = item.data[15:8];
        end
        cmd_request_next = 1'b1;
      end
      MODE_SUB_RD: begin
        if (item.offset == SUB_DOWN_LO || item.offset == SUB_DOWN_HI) begin
          rd = down_latch[item.offset[0]];
        end else if (item.offset == SUB_STATUS) begin
          rd = {7'd0, up_pending};
        end else begin
          rd = UNMAPPED;
        end
      end
      MODE_SUB_WR: begin
        if (item.offset == SUB_HANDSHAKE) begin
          down_pending_next = 1'b0;
          up_pending_next   = 1'b1;
        end else if (item.offset == SUB_CMD_EOI || item.offset == SUB_CMD_EOI2) begin
          cmd_in_service_next = 1'b0;
        end else if (item.offset == SUB_FM_EOI) begin
          fm_in_service_next = 1'b0;
        end else if (item.offset == SUB_UP_LO || item.offset == SUB_UP_HI) begin
          up_latch_next[item.offset[0]] = item.data[7:0];
        end
      end
      MODE_FM_LEVEL: begin
        fm_request_next = item.data[0];
      end
      MODE_INT_ACK: begin
        // command source outranks the FM timer
        if (cmd_ready) begin
          cmd_in_service_next = 1'b1;
          cmd_request_next    = 1'b0;
          rd = VEC_CMD;
        end else if (fm_ready) begin
          fm_in_service_next = 1'b1;
          rd = VEC_FM;
        end else begin
          spur = 1'b1;
        end
      end
      MODE_INIT: begin
        fm_request_next     = 1'b0;
        cmd_request_next    = 1'b0;
        fm_in_service_next  = 1'b0;
        cmd_in_service_next = 1'b0;
      end
      default: begin
        rd = VEC_NONE;
      end
    endcase
  end

  always_comb begin
    result.read_data = rd;
    result.int_line  = (fm_request_next && !fm_in_service_next) ||
                       (cmd_request_next && !cmd_in_service_next);
    result.spurious  = spur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_latch[0]  <= 8'd0;
      down_latch[1]  <= 8'd0;
      up_latch[0]    <= 8'd0;
      up_latch[1]    <= 8'd0;
      down_pending   <= 1'b0;
      up_pending     <= 1'b0;
      fm_request     <= 1'b0;
      cmd_request    <= 1'b0;
      fm_in_service  <= 1'b0;
      cmd_in_service <= 1'b0;
    end else if (fire) begin
      down_latch     <= down_latch_next;
      up_latch       <= up_latch_next;
      down_pending   <= down_pending_next;
      up_pending     <= up_pending_next;
      fm_request     <= fm_request_next;
      cmd_request    <= cmd_request_next;
      fm_in_service  <= fm_in_service_next;
      cmd_in_service <= cmd_in_service_next;
    end
  end

  `SMIC_ASSERT_IMP(a_spurious_iff_idle, clk, rst,
    fire && item.mode == MODE_INT_ACK, result.spurious == !line_now,
    "ack spurious flag disagrees with pending request state")
  `SMIC_ASSERT_NXT(a_cmd_ack_moves, clk, rst,
    fire && item.mode == MODE_INT_ACK && cmd_ready, cmd_in_service && !cmd_request,
    "command ack did not move request to in-service")
  `SMIC_ASSERT_NXT(a_init_clears, clk, rst,
    fire && item.mode == MODE_INIT, !line_now && !fm_in_service && !cmd_in_service,
    "init left interrupt state set")

endmodule

`default_nettype wire

>>> hw/rtl/sound_mailbox_irq_controller.sv
`default_nettype none
`include "sound_mailbox_irq_controller_assert.svh"
// An accepted transaction is registered in the input register, and its result in the result
// register, from which it leaves on m_axis. Throughput: one transaction per cycle while
// m_axis_tready is high; the two registers let one more transaction enter while a result
// waits on m_axis_tready. Reset (rst, synchronous, active high): mailboxes, pending, request
// and in-service flags clear to zero and both stages empty.

module sound_mailbox_irq_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // offset[4:0], data[20:5], byte_enables[22:21], pad
  input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // read_data[7:0], int_line[8], pad
  output logic             m_axis_tuser   // spurious[0]
);
  import smic_pkg::*;

  logic                 in_valid;
  smic_item_t           in_item;
  logic                 out_valid;
  smic_result_t         out_res;
  smic_result_t         core_res;
  logic                 advance;
  logic                 s_fire;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_fire) begin
      in_item.mode         <= smic_mode_t'(s_axis_tuser);
      in_item.offset       <= s_axis_tdata[4:0];
      in_item.data         <= s_axis_tdata[20:5];
      in_item.byte_enables <= s_axis_tdata[22:21];
    end
  end

  smic_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res.int_line, out_res.read_data};
  assign m_axis_tuser  = out_res.spurious;

  `SMIC_ASSERT_IMP(a_stall_only_when_full, clk, rst,
    !s_axis_tready, in_valid && out_valid && !m_axis_tready,
    "input stalled while a stage had room")
  `SMIC_ASSERT_NXT(a_advance_fills_out, clk, rst,
    advance, m_axis_tvalid,
    "advanced transaction did not reach the result register")
  `SMIC_ASSERT_NXT(a_accept_fills_in, clk, rst,
    s_fire, in_valid,
    "accepted transaction lost from the input register")

endmodule

`default_nettype wire
